// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the dispatcher RTL.
// Assertion text is compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising edge of clk_i, outside reset.
`define SPCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge of clk_i.
`define SPCD_NEVER(label, cond, msg) \
  `SPCD_ASSERT(label, !(cond), msg)

`else

`define SPCD_ASSERT(label, prop, msg)
`define SPCD_NEVER(label, cond, msg)

`endif

`endif

// ----- hw/rtl/spcd_pkg.sv -----
// Types and constants for the strict priority call dispatcher.
// No dependencies; imported by every dispatcher module.
`default_nettype none

package spcd_pkg;

  localparam int NumClasses = 4;
  localparam int IdW        = 16;
  localparam int LenW       = 16;
  localparam int EntryW     = IdW + LenW;
  localparam int TickW      = 16;

  typedef enum logic [1:0] {
    CLS_REGULAR  = 2'd0,
    CLS_SILVER   = 2'd1,
    CLS_GOLD     = 2'd2,
    CLS_PLATINUM = 2'd3
  } class_e;

  typedef enum logic {
    CMD_ARRIVAL = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_e;

  // Request from the dispatch stage to the class queues.
  typedef struct packed {
    logic   push;
    logic   pop;
    class_e cls;
  } q_cmd_t;

  // Per-class occupancy flags from the class queues.
  typedef struct packed {
    logic [NumClasses-1:0] nonempty;
    logic [NumClasses-1:0] full;
    logic [NumClasses-1:0] one_left;
  } q_stat_t;

  // Outcome of the priority pick.
  typedef struct packed {
    logic   found;
    class_e cls;
  } pick_t;

endpackage

`default_nettype wire

// ----- hw/rtl/spcd_arb.sv -----
// Strict priority pick among the non-empty class queues.
// Depends on spcd_pkg.
`default_nettype none

module spcd_arb (
  input  logic [spcd_pkg::NumClasses-1:0] nonempty_i,
  output spcd_pkg::pick_t                 pick_o
);
  import spcd_pkg::*;

  // Scan upward so the highest non-empty class wins.
  always_comb begin
    pick_o.found = 1'b0;
    pick_o.cls   = CLS_REGULAR;
    for (int c = 0; c < NumClasses; c++) begin
      if (nonempty_i[c]) begin
        pick_o.found = 1'b1;
        pick_o.cls   = class_e'(c[1:0]);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/spcd_queues.sv -----
// Four bounded FIFOs sharing one entry memory, with head pointers and fill counts.
// Depends on spcd_pkg.
`default_nettype none

module spcd_queues #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spcd_pkg::q_cmd_t          cmd_i,
  input  logic [spcd_pkg::EntryW-1:0] wr_entry_i,
  output spcd_pkg::q_stat_t         stat_o,
  output logic [spcd_pkg::EntryW-1:0] rd_entry_o
);
  import spcd_pkg::*;

  localparam int PtrW  = $clog2(QUEUE_DEPTH);
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SumW  = CntW + 1;
  localparam int Words = NumClasses * QUEUE_DEPTH;
  localparam int AddrW = $clog2(Words);
  localparam logic [CntW-1:0]  DepthC = CntW'(QUEUE_DEPTH);
  localparam logic [SumW-1:0]  DepthS = SumW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0]  LastP  = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [AddrW-1:0] DepthA = AddrW'(QUEUE_DEPTH);

  logic [EntryW-1:0] mem [Words];
  logic [EntryW-1:0] rd_entry_q;

  logic [PtrW-1:0] head_q  [NumClasses];
  logic [PtrW-1:0] head_d  [NumClasses];
  logic [CntW-1:0] count_q [NumClasses];
  logic [CntW-1:0] count_d [NumClasses];

  logic [SumW-1:0]  tail_sum;
  logic [PtrW-1:0]  tail_pos;
  logic [AddrW-1:0] base_addr;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  logic             do_push;

  always_comb begin
    for (int c = 0; c < NumClasses; c++) begin
      stat_o.nonempty[c] = (count_q[c] != '0);
      stat_o.full[c]     = (count_q[c] == DepthC);
      stat_o.one_left[c] = (count_q[c] == CntW'(1));
    end
  end

  // Tail slot: head plus fill level, wrapped once.
  always_comb begin
    tail_sum  = SumW'(head_q[cmd_i.cls]) + SumW'(count_q[cmd_i.cls]);
    tail_pos  = (tail_sum >= DepthS) ? PtrW'(tail_sum - DepthS) : PtrW'(tail_sum);
    base_addr = AddrW'(AddrW'(cmd_i.cls) * DepthA);
    wr_addr   = base_addr + AddrW'(tail_pos);
    rd_addr   = base_addr + AddrW'(head_q[cmd_i.cls]);
    do_push   = cmd_i.push && !stat_o.full[cmd_i.cls];
  end

  always_comb begin
    for (int c = 0; c < NumClasses; c++) begin
      head_d[c]  = head_q[c];
      count_d[c] = count_q[c];
    end
    if (do_push) begin
      count_d[cmd_i.cls] = count_q[cmd_i.cls] + CntW'(1);
    end else if (cmd_i.pop) begin
      count_d[cmd_i.cls] = count_q[cmd_i.cls] - CntW'(1);
      head_d[cmd_i.cls]  = (head_q[cmd_i.cls] == LastP) ? '0
                                                        : head_q[cmd_i.cls] + PtrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumClasses; c++) begin
        head_q[c]  <= '0;
        count_q[c] <= '0;
      end
    end else begin
      for (int c = 0; c < NumClasses; c++) begin
        head_q[c]  <= head_d[c];
        count_q[c] <= count_d[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_addr] <= wr_entry_i;
    end
    if (cmd_i.pop) begin
      rd_entry_q <= mem[rd_addr];
    end
  end

  assign rd_entry_o = rd_entry_q;

endmodule

`default_nettype wire

// ----- hw/rtl/strict_priority_call_dispatcher.sv -----
// Top level of the strict priority call dispatcher: input stage, dispatch and server
// state, result stage. Depends on spcd_pkg, spcd_queues, spcd_arb, assert_macros.svh.
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------------------------
//   in      | in_valid_i/in_ready_o  | cmd, caller_class, caller_id, call_length
//   out     | out_valid_o/out_ready_i| answered, answered_id, answered_class,
//           |                        | dropped, all_idle, tick_number
//
// One item per cycle while the output is not stalled; each item passes the input
// register, then the result register together with the queue memory read.
// The head entry of the answered class is read from the queue memory in the dispatch
// cycle, so the new call length reaches the server countdown at the next dispatch.
// Reset clears all control state, heads and counts; queue contents are not cleared.
// A stalled output holds the result stage and the input stage behind it.
`default_nettype none
`include "assert_macros.svh"

module strict_priority_call_dispatcher #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [1:0]  caller_class_i,
  input  logic [15:0] caller_id_i,
  input  logic [15:0] call_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        answered_o,
  output logic [15:0] answered_id_o,
  output logic [1:0]  answered_class_o,
  output logic        dropped_o,
  output logic        all_idle_o,
  output logic [15:0] tick_number_o
);
  import spcd_pkg::*;

  // Input stage: hold one transfer until the dispatch stage takes it.
  logic              in_valid_q;
  cmd_e              cmd_q;
  class_e            cls_q;
  logic [IdW-1:0]    id_q;
  logic [LenW-1:0]   len_q;

  // Server and tick state.
  logic              busy_q;
  logic [LenW-1:0]   rem_q;
  logic              len_pend_q;   // rem comes from the memory read still in flight
  logic [TickW-1:0]  tick_cnt_q;

  // Result stage.
  logic              out_valid_q;
  logic              ans_q;
  class_e            ans_cls_q;
  logic              drop_q;
  logic              idle_q;
  logic [TickW-1:0]  tick_q;

  logic              advance;
  logic              fire;
  logic              is_tick;
  logic [LenW-1:0]   rem_eff;
  logic [LenW-1:0]   rem_dec;
  logic              srv_free;
  logic              do_pop;
  logic              drop;
  logic              busy_after;
  logic              empty_after;
  logic [NumClasses-1:0] pop_mask;

  q_cmd_t            q_cmd;
  q_stat_t           q_stat;
  pick_t             pick;
  logic [EntryW-1:0] rd_entry;

  // The result register frees when empty or when its transfer completes.
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= cmd_e'(cmd_i);
      cls_q <= class_e'(caller_class_i);
      id_q  <= caller_id_i;
      len_q <= call_length_i;
    end
  end

  spcd_arb u_arb (
    .nonempty_i (q_stat.nonempty),
    .pick_o     (pick)
  );

  spcd_queues #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queues (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (q_cmd),
    .wr_entry_i ({id_q, len_q}),
    .stat_o     (q_stat),
    .rd_entry_o (rd_entry)
  );

  // Dispatch: on a tick, count the server down, then pick a caller if it is free.
  always_comb begin
    is_tick  = (cmd_q == CMD_TICK);
    rem_eff  = len_pend_q ? rd_entry[LenW-1:0] : rem_q;
    rem_dec  = (rem_eff != '0) ? rem_eff - LenW'(1) : '0;
    srv_free = !busy_q || (rem_dec == '0);
    do_pop   = is_tick && srv_free && pick.found;
    drop     = !is_tick && q_stat.full[cls_q];

    busy_after = is_tick ? (do_pop || !srv_free) : busy_q;

    // Queues end empty when nothing stays behind the pop and nothing was pushed.
    pop_mask    = do_pop ? ((NumClasses'(1) << pick.cls) & q_stat.one_left) : '0;
    empty_after = ((q_stat.nonempty & ~pop_mask) == '0) && !(!is_tick && !drop);

    q_cmd.push = fire && !is_tick;
    q_cmd.pop  = fire && do_pop;
    q_cmd.cls  = is_tick ? pick.cls : cls_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      rem_q      <= '0;
      len_pend_q <= 1'b0;
      tick_cnt_q <= '0;
    end else if (fire) begin
      busy_q     <= busy_after;
      rem_q      <= is_tick ? rem_dec : rem_eff;
      len_pend_q <= do_pop;
      if (is_tick) begin
        tick_cnt_q <= tick_cnt_q + TickW'(1);
      end
    end
  end

  // Result register: load on dispatch, drop the valid once the transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ans_q     <= do_pop;
      ans_cls_q <= do_pop ? pick.cls : CLS_REGULAR;
      drop_q    <= drop;
      idle_q    <= !busy_after && empty_after;
      tick_q    <= tick_cnt_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign answered_o       = ans_q;
  assign answered_id_o    = ans_q ? rd_entry[EntryW-1:LenW] : '0;
  assign answered_class_o = ans_cls_q;
  assign dropped_o        = drop_q;
  assign all_idle_o       = idle_q;
  assign tick_number_o    = tick_q;

  `SPCD_NEVER(a_ans_excl, out_valid_o && answered_o && (dropped_o || all_idle_o),
              "answered result also flags drop or idle")
  `SPCD_ASSERT(a_stall_src, !in_ready_o |-> (out_valid_o && !out_ready_i),
               "input held back without an output stall")
  `SPCD_ASSERT(a_pend_busy, len_pend_q |-> busy_q,
               "call length pending while server is free")
  `SPCD_ASSERT(a_tick_step, (fire && is_tick) |=> (tick_cnt_q == $past(tick_cnt_q) + 16'd1),
               "tick counter did not advance on a tick")

endmodule

`default_nettype wire
